@@ design/spq_pkg.sv @@
// shared types and constants for the sorted priority queue
// no dependencies
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int PRIO_W      = 8;
  localparam int COUNT_W     = 5;
  localparam int ENTRY_W     = ID_W + PRIO_W;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_ENQ_SCAN,
    S_ENQ_HEAD
  } state_e;

  typedef struct packed {
    logic                     action;
    logic [ID_W-1:0]          proc_id;
    logic signed [PRIO_W-1:0] priority_req;
  } spq_in_t;

  typedef struct packed {
    status_e                  status;
    logic [ID_W-1:0]          out_id;
    logic signed [PRIO_W-1:0] out_priority;
    logic [COUNT_W-1:0]       count;
  } spq_out_t;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ design/spq_ram.sv @@
// simple dual-port ram, one write and one registered read per cycle
// no dependencies
module spq_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/spq_ctrl.sv @@
// sequencer: circular sorted list in ram, insertion walks back from the tail
// depends on spq_pkg
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  spq_in_t  in_word_i,
  input  entry_t   rdata_i,
  output logic     busy,
  output mem_req_t mem_req_o,
  output logic     done_o,
  output spq_out_t result_o
);

  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  entry_t           item_q, item_d;
  logic             res_vld_q, res_vld_d;
  spq_out_t         res_q, res_d;
  entry_t           new_entry;
  logic             accept;
  logic             stop_here;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;
    sum     = SUM_W'(base) + SUM_W'(off);
    wrapped = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
    return wrapped[IDX_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] cnt_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] ext;
    ext = (CNT_W + COUNT_W)'(c);
    return ext[COUNT_W-1:0];
  endfunction

  assign accept    = start && (state_q == S_IDLE);
  assign new_entry = '{id: in_word_i.proc_id, prio: in_word_i.priority_req};
  assign stop_here = (rdata_i.prio >= item_q.prio);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_word_i.action == ACT_DEQ) begin
            if (count_q != '0) state_d = S_DEQ;
          end else if (count_q != DEPTH_C && count_q != '0) begin
            state_d = S_ENQ_SCAN;
          end
        end
      end
      S_DEQ:      state_d = S_IDLE;
      S_ENQ_SCAN: begin
        if (stop_here) state_d = S_IDLE;
        else if (pos_q == ONE_C) state_d = S_ENQ_HEAD;
      end
      S_ENQ_HEAD: state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs: memory port and handshake
  always_comb begin
    mem_req_o = '{we: 1'b0, waddr: head_q, wdata: item_q, raddr: head_q};
    busy      = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_word_i.action == ACT_ENQ) begin
          if (count_q == '0) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = new_entry;
          end else begin
            mem_req_o.raddr = phys(head_q, count_q - ONE_C);
          end
        end
      end
      S_DEQ: begin
      end
      S_ENQ_SCAN: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = phys(head_q, pos_q);
        mem_req_o.wdata = stop_here ? item_q : rdata_i;
        mem_req_o.raddr = phys(head_q, pos_q - TWO_C);
      end
      S_ENQ_HEAD: begin
        mem_req_o.we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    pos_d     = pos_q;
    item_d    = item_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '{status: ST_ENQUEUED, out_id: '0, out_priority: '0,
                    count: cnt_field(count_q)};
          if (in_word_i.action == ACT_DEQ) begin
            if (count_q == '0) begin
              res_vld_d    = 1'b1;
              res_d.status = ST_EMPTY;
            end
          end else if (count_q == DEPTH_C) begin
            res_vld_d    = 1'b1;
            res_d.status = ST_FULL;
          end else if (count_q == '0) begin
            res_vld_d   = 1'b1;
            count_d     = ONE_C;
            res_d.count = cnt_field(ONE_C);
          end else begin
            pos_d  = count_q;
            item_d = new_entry;
          end
        end
      end
      S_DEQ: begin
        res_vld_d = 1'b1;
        head_d    = phys(head_q, ONE_C);
        count_d   = count_q - ONE_C;
        res_d     = '{status: ST_DEQUEUED, out_id: rdata_i.id,
                      out_priority: rdata_i.prio, count: cnt_field(count_q - ONE_C)};
      end
      S_ENQ_SCAN: begin
        pos_d = pos_q - ONE_C;
        if (stop_here) begin
          res_vld_d = 1'b1;
          count_d   = count_q + ONE_C;
          res_d     = '{status: ST_ENQUEUED, out_id: '0, out_priority: '0,
                        count: cnt_field(count_q + ONE_C)};
        end
      end
      S_ENQ_HEAD: begin
        res_vld_d = 1'b1;
        count_d   = count_q + ONE_C;
        res_d     = '{status: ST_ENQUEUED, out_id: '0, out_priority: '0,
                      count: cnt_field(count_q + ONE_C)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign done_o   = res_vld_q;
  assign result_o = res_q;

endmodule

@@ design/sorted_priority_queue_top.sv @@
// full, empty or first entry answer straight from idle, dequeue passes through S_DEQ, other
// enqueue through S_ENQ_SCAN until it stops, then through S_ENQ_HEAD if it reaches the head
// throughput: one word at a time; insertion moves one entry per cycle through
// the single ram write port, walking back from the tail
// reset clears count, head and sequencer; ram contents are left as they are
// results are registered on result_o, done_o high for one cycle; the receiver cannot stall
// top level of the sorted priority queue; depends on spq_pkg, spq_ram, spq_ctrl
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  spq_in_t  in_word_i,
  output logic     busy,
  output logic     done_o,
  output spq_out_t result_o
);

  mem_req_t mem_req;
  entry_t   rdata;

  spq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .in_word_i (in_word_i),
    .rdata_i   (rdata),
    .busy      (busy),
    .mem_req_o (mem_req),
    .done_o    (done_o),
    .result_o  (result_o)
  );

  spq_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

`ifndef SYNTHESIS
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == ST_FULL |-> result_o.count == COUNT_W'(QUEUE_DEPTH))
    else $error("full reported with wrong count");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == ST_EMPTY |-> result_o.count == '0 &&
      result_o.out_id == '0 && result_o.out_priority == '0)
    else $error("empty reported with nonzero fields");

  a_item_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o || busy)
    else $error("accepted word neither finished nor in progress");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("sequencer finished without a result");
`endif

endmodule

@@ verif/testbench.sv @@
// self-checking bench for sorted_priority_queue_top: directed table, then random traffic
// checks each result word against its typed table row, else against a behavioral priority queue model
// depends on spq_pkg and the sorted priority queue rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  typedef struct {
    spq_in_t  word;
    bit       typed;
    spq_out_t want;
  } dir_row_t;

  typedef struct {
    bit       typed;
    spq_out_t want;
  } hint_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  spq_in_t  in_word_i;
  logic     busy;
  logic     done_o;
  spq_out_t result_o;

  entry_t      held [QUEUE_DEPTH];
  int unsigned held_n = 0;

  spq_out_t pending_results [$];
  hint_t    hints [$];
  dir_row_t dir_rows [$];

  int fails = 0;
  int words_sent = 0;
  int n_enq = 0;
  int n_deq = 0;
  int n_empty = 0;
  int n_full = 0;

  sorted_priority_queue_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .in_word_i(in_word_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic spq_out_t pq_update(spq_in_t w);
    spq_out_t    r;
    int unsigned pos;
    r = '0;
    if (w.action == ACT_ENQ) begin
      if (held_n >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_n && $signed(held[pos].prio) >= $signed(w.priority_req)) pos++;
        for (int i = held_n; i > pos; i--) held[i] = held[i-1];
        held[pos].id   = w.proc_id;
        held[pos].prio = w.priority_req;
        held_n++;
        r.status = ST_ENQUEUED;
      end
    end else begin
      if (held_n == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status       = ST_DEQUEUED;
        r.out_id       = held[0].id;
        r.out_priority = held[0].prio;
        for (int i = 1; i < held_n; i++) held[i-1] = held[i];
        held_n--;
      end
    end
    r.count = COUNT_W'(held_n);
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic act, logic [ID_W-1:0] id,
                                      logic signed [PRIO_W-1:0] p, bit typed,
                                      status_e st, logic [ID_W-1:0] oid,
                                      logic signed [PRIO_W-1:0] opri,
                                      logic [COUNT_W-1:0] cnt);
    dir_row_t r;
    r.word.action       = act;
    r.word.proc_id      = id;
    r.word.priority_req = p;
    r.typed             = typed;
    r.want.status       = st;
    r.want.out_id       = oid;
    r.want.out_priority = opri;
    r.want.count        = cnt;
    return r;
  endfunction

  task automatic check_word(spq_out_t want, spq_out_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fails++;
    end
    if (got.out_id !== want.out_id) begin
      $error("out_id: expected %h, got %h", want.out_id, got.out_id);
      fails++;
    end
    if (got.out_priority !== want.out_priority) begin
      $error("out_priority: expected %0d, got %0d", want.out_priority, got.out_priority);
      fails++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      fails++;
    end
  endtask

  task automatic send_word(spq_in_t w, bit typed, spq_out_t want, bit calm);
    hint_t h;
    int    gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 29) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    h.typed = typed;
    h.want  = want;
    hints.push_back(h);
    start     <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy);
    words_sent++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    spq_out_t want;
    spq_out_t pred;
    hint_t    h;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected, status %0d", result_o.status);
          fails++;
        end else begin
          want = pending_results.pop_front();
          check_word(want, result_o);
        end
        case (result_o.status)
          ST_ENQUEUED: n_enq++;
          ST_DEQUEUED: n_deq++;
          ST_EMPTY:    n_empty++;
          default:     n_full++;
        endcase
      end
      if (start && !busy) begin
        pred = pq_update(in_word_i);
        if (hints.size() > 0) begin
          h = hints.pop_front();
          pending_results.push_back(h.typed ? h.want : pred);
        end else begin
          pending_results.push_back(pred);
        end
      end
    end
  end

  initial begin
    spq_in_t  w;
    spq_out_t none;
    int       enq_pct;
    int       waited;

    rst_ni    = 1'b0;
    start     = 1'b0;
    in_word_i = '0;
    none      = '0;
    enq_pct   = 50;

    // empty, extremes, equal priorities in arrival order, a dequeue, then fill to full, one rejected enqueue, a dequeue
    dir_rows.push_back(mk_row(ACT_DEQ, 16'h0000, 8'sd0, 1, ST_EMPTY, 16'h0, 8'sd0, 5'd0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'hffff, 8'sd127, 1, ST_ENQUEUED, 16'h0, 8'sd0, 5'd1));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h0000, -8'sd128, 1, ST_ENQUEUED, 16'h0, 8'sd0, 5'd2));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h1234, 8'sd0, 1, ST_ENQUEUED, 16'h0, 8'sd0, 5'd3));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h1235, 8'sd0, 1, ST_ENQUEUED, 16'h0, 8'sd0, 5'd4));
    dir_rows.push_back(mk_row(ACT_DEQ, 16'h5a5a, -8'sd1, 1, ST_DEQUEUED, 16'hffff, 8'sd127,
                              5'd3));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h8000, 8'sd127, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h7fff, -8'sd128, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h0001, -8'sd1, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h0002, 8'sd1, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h0003, 8'sd0, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h0004, 8'sd127, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'haaaa, 8'sd5, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h5555, -8'sd5, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h00ff, 8'sd0, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'hff00, -8'sd128, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'h0f0f, 8'sd64, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'hf0f0, -8'sd64, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'hbeef, 8'sd0, 0, ST_ENQUEUED, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_ENQ, 16'hcafe, 8'sd99, 1, ST_FULL, 16'h0, 8'sd0, 5'd16));
    dir_rows.push_back(mk_row(ACT_DEQ, 16'hffff, -8'sd1, 0, ST_DEQUEUED, 0, 0, 0));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want, 0);

    for (int i = 0; i < 1980; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(2))
          0:       enq_pct = 15;
          1:       enq_pct = 50;
          default: enq_pct = 85;
        endcase
      end
      w.action  = ($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
      w.proc_id = ID_W'($urandom);
      if ($urandom_range(1) == 0) w.priority_req = PRIO_W'($urandom);
      else w.priority_req = PRIO_W'($urandom_range(4)) - PRIO_W'(2);
      send_word(w, 0, none, (i >= 700 && i < 1100));
    end
    start <= 1'b0;

    waited = 0;
    while (pending_results.size() > 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (25) @(posedge clk_i);

    $display("sent %0d words: %0d enqueued, %0d dequeued, %0d empty, %0d rejected as full",
             words_sent, n_enq, n_deq, n_empty, n_full);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sorted_priority_queue_top.f @@
design/spq_pkg.sv
design/spq_ram.sv
design/spq_ctrl.sv
design/sorted_priority_queue_top.sv
verif/testbench.sv
